FILE: rtl/core/free_list_allocator_core_macros.svh
// ----------------------------------------------------------------------------
// free_list_allocator_core_macros.svh
// Assertion macros shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef FREE_LIST_ALLOCATOR_CORE_MACROS_SVH
`define FREE_LIST_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define FLA_ASSERT_IMP(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, disabled in reset.
`define FLA_ASSERT_NXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

FILE: rtl/core/fla_pkg.sv
// ----------------------------------------------------------------------------
// fla_pkg
// Widths, constants and types of the free-list allocator.
// ----------------------------------------------------------------------------
package fla_pkg;

  localparam int HEAP_UNITS = 4096;
  localparam int UNIT_BYTES = 16;
  localparam int IDX_W      = $clog2(HEAP_UNITS);
  localparam int SIZE_W     = IDX_W + 1;
  localparam int SUM_W      = IDX_W + 2;
  localparam int BYTES_W    = 16;
  localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
  localparam int WALK_LIMIT = 4 * HEAP_UNITS + 16;
  localparam int STEP_W     = $clog2(WALK_LIMIT + 2);
  localparam int MIN_GROW_RESET = 4;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } fla_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALLOC_INIT,
    ST_ALLOC_RD,
    ST_ALLOC_WAIT_P,
    ST_ALLOC_CHECK,
    ST_ALLOC_SPLIT,
    ST_ALLOC_RESUME,
    ST_INS_WALK,
    ST_INS_R1,
    ST_INS_R2,
    ST_INS_R3,
    ST_INS_W2,
    ST_OUT
  } fla_state_t;

endpackage

FILE: rtl/core/fla_req_if.sv
// ----------------------------------------------------------------------------
// fla_req_if
// Request channel: valid/ready handshake with an allocate or free item.
// ----------------------------------------------------------------------------
interface fla_req_if
  import fla_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [BYTES_W-1:0]   request_bytes;
  logic [IDX_W-1:0]     block_address;

  modport source (output valid, operation, request_bytes, block_address, input ready);
  modport sink   (input valid, operation, request_bytes, block_address, output ready);
endinterface

FILE: rtl/core/fla_rsp_if.sv
// ----------------------------------------------------------------------------
// fla_rsp_if
// Result channel: valid/ready handshake with the granted address.
// ----------------------------------------------------------------------------
interface fla_rsp_if
  import fla_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] result_address;

  modport source (output valid, result_address, input ready);
  modport sink   (input valid, result_address, output ready);
endinterface

FILE: rtl/core/free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// free_list_allocator_core
// First-fit allocator with coalescing; block headers live in two RAMs.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake            Payload
// in_req   in   valid & ready        operation, request_bytes, block_address
// out_rsp  out  valid & ready        result_address
// cfg      in   cfg_we (no ready)    cfg_wdata = min_grow_units
//
// One item at a time. An allocate visits the free-list nodes in turn from the
// rover, writes a second header for a split and first builds the sentinel on
// the very first allocate; a free walks to the insertion point, reads the
// headers and writes the merges or links. The header RAMs have a registered
// read. A grow adds an insert walk and its merge writes. A result waits in the
// output register while the next item is accepted; a full output register
// holds the sequencer. Reset is synchronous; the header RAMs are not cleared.
// ----------------------------------------------------------------------------
`include "free_list_allocator_core_macros.svh"

module free_list_allocator_core
  import fla_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  fla_req_if.sink          in_req,
  fla_rsp_if.source        out_rsp,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_wdata
);

  localparam logic [SIZE_W-1:0] HEAP_TOP = SIZE_W'(HEAP_UNITS);
  localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(WALK_LIMIT);

  // header RAMs
  logic [IDX_W-1:0]  next_mem [HEAP_UNITS];
  logic [SIZE_W-1:0] size_mem [HEAP_UNITS];
  logic [IDX_W-1:0]  next_q, next_raddr, next_waddr, next_wdata;
  logic [SIZE_W-1:0] size_q, size_wdata;
  logic [IDX_W-1:0]  size_raddr, size_waddr;
  logic              next_we, size_we;

  fla_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]  rover_r, rover_nxt;
  logic [SIZE_W-1:0] ab_r, ab_nxt;
  logic              started_r, started_nxt;
  logic [IDX_W-1:0]  min_grow_r;
  logic [SIZE_W-1:0] need_r, need_nxt;
  logic [IDX_W-1:0]  prev_r, prev_nxt, p_r, p_nxt;
  logic [IDX_W-1:0]  blk_r, blk_nxt, cur_r, cur_nxt, nx_r, nx_nxt;
  logic [SIZE_W-1:0] sb_r, sb_nxt, snx_r, snx_nxt, sc_r, sc_nxt;
  logic [IDX_W-1:0]  nnx_r, nnx_nxt;
  logic [STEP_W-1:0] asteps_r, asteps_nxt, isteps_r, isteps_nxt;
  logic              for_alloc_r, for_alloc_nxt;
  logic [IDX_W-1:0]  res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_data_r, out_data_nxt;

  // request size in units, header included
  logic [BYTES_W:0]  bytes_up;
  logic [SIZE_W-1:0] need_in;
  assign bytes_up = {1'b0, in_req.request_bytes} + (BYTES_W+1)'(UNIT_BYTES - 1);
  assign need_in  = SIZE_W'(bytes_up >> UNIT_SHIFT) + SIZE_W'(1);

  assign in_req.ready       = (state_r == ST_IDLE);
  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.result_address = out_data_r;

  // RAM ports: one write and one registered read each
  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    next_q <= next_mem[next_raddr];
  end

  always_ff @(posedge clk) begin
    if (size_we) begin
      size_mem[size_waddr] <= size_wdata;
    end
    size_q <= size_mem[size_raddr];
  end

  // control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rover_r     <= '0;
      ab_r        <= SIZE_W'(1);
      started_r   <= 1'b0;
      min_grow_r  <= IDX_W'(MIN_GROW_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rover_r     <= rover_nxt;
      ab_r        <= ab_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        min_grow_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    need_r      <= need_nxt;
    prev_r      <= prev_nxt;
    p_r         <= p_nxt;
    blk_r       <= blk_nxt;
    cur_r       <= cur_nxt;
    nx_r        <= nx_nxt;
    sb_r        <= sb_nxt;
    snx_r       <= snx_nxt;
    sc_r        <= sc_nxt;
    nnx_r       <= nnx_nxt;
    asteps_r    <= asteps_nxt;
    isteps_r    <= isteps_nxt;
    for_alloc_r <= for_alloc_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  // sequencer
  always_comb begin
    logic [SIZE_W-1:0] rem;
    logic [SIZE_W-1:0] nu;
    logic [STEP_W-1:0] astep_inc, istep_inc;
    logic              found, merge_up, merge_lo;
    logic [SIZE_W-1:0] sbn;
    logic [IDX_W-1:0]  nbn;

    state_nxt     = state_r;
    rover_nxt     = rover_r;
    ab_nxt        = ab_r;
    started_nxt   = started_r;
    need_nxt      = need_r;
    prev_nxt      = prev_r;
    p_nxt         = p_r;
    blk_nxt       = blk_r;
    cur_nxt       = cur_r;
    nx_nxt        = nx_r;
    sb_nxt        = sb_r;
    snx_nxt       = snx_r;
    sc_nxt        = sc_r;
    nnx_nxt       = nnx_r;
    asteps_nxt    = asteps_r;
    isteps_nxt    = isteps_r;
    for_alloc_nxt = for_alloc_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_data_nxt  = out_data_r;
    next_raddr    = cur_r;
    size_raddr    = cur_r;
    next_we       = 1'b0;
    next_waddr    = cur_r;
    next_wdata    = blk_r;
    size_we       = 1'b0;
    size_waddr    = cur_r;
    size_wdata    = sb_r;

    rem       = size_q - need_r;
    nu        = (need_r < {1'b0, min_grow_r}) ? {1'b0, min_grow_r} : need_r;
    astep_inc = asteps_r + STEP_W'(1);
    istep_inc = isteps_r + STEP_W'(1);
    found     = ((blk_r > cur_r) && (blk_r < next_q)) ||
                ((cur_r >= next_q) && ((blk_r > cur_r) || (blk_r < next_q)));
    merge_up  = (SUM_W'(blk_r) + SUM_W'(sb_r)) == SUM_W'(nx_r);
    sbn       = merge_up ? (sb_r + snx_r) : sb_r;
    nbn       = merge_up ? nnx_r : nx_r;
    merge_lo  = (SUM_W'(cur_r) + SUM_W'(sc_r)) == SUM_W'(blk_r);

    unique case (state_r)
      // take an item and dispatch it
      ST_IDLE: begin
        if (in_req.valid) begin
          res_nxt    = '0;
          asteps_nxt = '0;
          if (fla_op_t'(in_req.operation) == OP_ALLOC) begin
            need_nxt = need_in;
            prev_nxt = rover_r;
            if (!started_r) begin
              state_nxt = ST_ALLOC_INIT;
            end else begin
              next_raddr = rover_r;
              state_nxt  = ST_ALLOC_WAIT_P;
            end
          end else if (started_r && (in_req.block_address >= IDX_W'(2)) &&
                       ({1'b0, in_req.block_address - IDX_W'(1)} < ab_r)) begin
            blk_nxt       = in_req.block_address - IDX_W'(1);
            cur_nxt       = rover_r;
            isteps_nxt    = '0;
            for_alloc_nxt = 1'b0;
            next_raddr    = rover_r;
            state_nxt     = ST_INS_WALK;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end

      // build the sentinel at unit 0
      ST_ALLOC_INIT: begin
        next_we     = 1'b1;
        next_waddr  = '0;
        next_wdata  = '0;
        size_we     = 1'b1;
        size_waddr  = '0;
        size_wdata  = '0;
        rover_nxt   = '0;
        prev_nxt    = '0;
        started_nxt = 1'b1;
        state_nxt   = ST_ALLOC_RD;
      end

      ST_ALLOC_RD: begin
        next_raddr = prev_r;
        state_nxt  = ST_ALLOC_WAIT_P;
      end

      // fetch the header of the candidate block
      ST_ALLOC_WAIT_P: begin
        p_nxt      = next_q;
        next_raddr = next_q;
        size_raddr = next_q;
        state_nxt  = ST_ALLOC_CHECK;
      end

      ST_ALLOC_CHECK: begin
        if (size_q >= need_r) begin
          rover_nxt = prev_r;
          if (size_q == need_r) begin
            next_we    = 1'b1;
            next_waddr = prev_r;
            next_wdata = next_q;
            res_nxt    = p_r + IDX_W'(1);
            state_nxt  = ST_OUT;
          end else begin
            size_we    = 1'b1;
            size_waddr = p_r;
            size_wdata = rem;
            p_nxt      = p_r + rem[IDX_W-1:0];
            state_nxt  = ST_ALLOC_SPLIT;
          end
        end else if (p_r == rover_r) begin
          // wrapped around: grow the arena
          if ((ab_r > HEAP_TOP) || (nu > (HEAP_TOP - ab_r))) begin
            res_nxt   = '0;
            state_nxt = ST_OUT;
          end else begin
            size_we       = 1'b1;
            size_waddr    = ab_r[IDX_W-1:0];
            size_wdata    = nu;
            ab_nxt        = ab_r + nu;
            blk_nxt       = ab_r[IDX_W-1:0];
            cur_nxt       = rover_r;
            isteps_nxt    = '0;
            for_alloc_nxt = 1'b1;
            next_raddr    = rover_r;
            state_nxt     = ST_INS_WALK;
          end
        end else begin
          prev_nxt   = p_r;
          p_nxt      = next_q;
          asteps_nxt = astep_inc;
          if (astep_inc > STEP_MAX) begin
            res_nxt   = '0;
            state_nxt = ST_OUT;
          end else begin
            next_raddr = next_q;
            size_raddr = next_q;
          end
        end
      end

      // write the header of the tail handed out
      ST_ALLOC_SPLIT: begin
        size_we    = 1'b1;
        size_waddr = p_r;
        size_wdata = need_r;
        res_nxt    = p_r + IDX_W'(1);
        state_nxt  = ST_OUT;
      end

      // continue the search after a grow
      ST_ALLOC_RESUME: begin
        asteps_nxt = astep_inc;
        prev_nxt   = rover_r;
        if (astep_inc > STEP_MAX) begin
          res_nxt   = '0;
          state_nxt = ST_OUT;
        end else begin
          next_raddr = rover_r;
          state_nxt  = ST_ALLOC_WAIT_P;
        end
      end

      // walk to the insertion point
      ST_INS_WALK: begin
        if (found) begin
          nx_nxt     = next_q;
          size_raddr = blk_r;
          next_raddr = next_q;
          state_nxt  = ST_INS_R1;
        end else begin
          cur_nxt    = next_q;
          isteps_nxt = istep_inc;
          if (istep_inc > STEP_MAX) begin
            state_nxt = for_alloc_r ? ST_ALLOC_RESUME : ST_OUT;
          end else begin
            next_raddr = next_q;
          end
        end
      end

      ST_INS_R1: begin
        sb_nxt     = size_q;
        nnx_nxt    = next_q;
        size_raddr = nx_r;
        state_nxt  = ST_INS_R2;
      end

      ST_INS_R2: begin
        snx_nxt    = size_q;
        size_raddr = cur_r;
        state_nxt  = ST_INS_R3;
      end

      // merge with the upper neighbor or link to it
      ST_INS_R3: begin
        sc_nxt     = size_q;
        size_we    = merge_up;
        size_waddr = blk_r;
        size_wdata = sbn;
        next_we    = 1'b1;
        next_waddr = blk_r;
        next_wdata = nbn;
        sb_nxt     = sbn;
        nnx_nxt    = nbn;
        state_nxt  = ST_INS_W2;
      end

      // merge with the lower neighbor or link to it
      ST_INS_W2: begin
        next_we    = 1'b1;
        next_waddr = cur_r;
        size_waddr = cur_r;
        size_wdata = sc_r + sb_r;
        if (merge_lo) begin
          size_we    = 1'b1;
          next_wdata = nnx_r;
        end else begin
          next_wdata = blk_r;
        end
        rover_nxt = cur_r;
        state_nxt = for_alloc_r ? ST_ALLOC_RESUME : ST_OUT;
      end

      // hand the result to the output register
      ST_OUT: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // checks
  `FLA_ASSERT_IMP(a_break_in_range, clk, rst_n, 1'b1, ab_r <= HEAP_TOP)
  `FLA_ASSERT_NXT(a_break_monotonic, clk, rst_n, 1'b1, ab_r >= $past(ab_r))
  `FLA_ASSERT_NXT(a_started_sticks, clk, rst_n, started_r, started_r)
  `FLA_ASSERT_NXT(a_out_wait, clk, rst_n, (state_r == ST_OUT) && out_valid_r && !out_rsp.ready, state_r == ST_OUT)

endmodule

FILE: dv/fla_tb_checker.sv
// ----------------------------------------------------------------------------
// fla_tb_checker
// Watches the request, result and register ports of the allocator, keeps its
// own copy of the free list and arena, predicts every granted address and
// compares each result item against the oldest prediction.
// ----------------------------------------------------------------------------
module fla_tb_checker
  import fla_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  fla_req_if               req,
  fla_rsp_if               rsp,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               due_count
);

  // Shadow headers and allocator state
  logic [IDX_W-1:0]  hdr_next [HEAP_UNITS];
  logic [SIZE_W-1:0] hdr_size [HEAP_UNITS];
  int unsigned       rover_q;
  int unsigned       brk_q;
  bit                started_q;
  int unsigned       grow_min_q;
  logic [IDX_W-1:0]  addr_due [$];

  function automatic int unsigned rd_next(int unsigned i);
    return (i < HEAP_UNITS) ? int'(hdr_next[i]) : 0;
  endfunction

  function automatic int unsigned rd_size(int unsigned i);
    return (i < HEAP_UNITS) ? int'(hdr_size[i]) : 0;
  endfunction

  function automatic void wr_next(int unsigned i, int unsigned v);
    if (i < HEAP_UNITS) hdr_next[i] = v[IDX_W-1:0];
  endfunction

  function automatic void wr_size(int unsigned i, int unsigned v);
    if (i < HEAP_UNITS) hdr_size[i] = v[SIZE_W-1:0];
  endfunction

  // Link a block into the address-ordered list and merge with neighbors
  function automatic void link_block(int unsigned blk);
    int unsigned cur;
    int unsigned nx;
    int unsigned steps;
    cur = rover_q;
    steps = 0;
    while (1) begin
      nx = rd_next(cur);
      if (blk > cur && blk < nx) break;
      if (cur >= nx && (blk > cur || blk < nx)) break;
      cur = nx;
      steps++;
      if (steps > WALK_LIMIT) return;
    end
    nx = rd_next(cur);
    if (blk + rd_size(blk) == nx) begin
      wr_size(blk, rd_size(blk) + rd_size(nx));
      wr_next(blk, rd_next(nx));
    end else begin
      wr_next(blk, nx);
    end
    if (cur + rd_size(cur) == blk) begin
      wr_size(cur, rd_size(cur) + rd_size(blk));
      wr_next(cur, rd_next(blk));
    end else begin
      wr_next(cur, blk);
    end
    rover_q = cur;
  endfunction

  function automatic bit grow_heap(int unsigned need);
    int unsigned nu;
    int unsigned hdr;
    nu = (need < grow_min_q) ? grow_min_q : need;
    if (brk_q > HEAP_UNITS || nu > HEAP_UNITS - brk_q) return 0;
    hdr = brk_q;
    wr_size(hdr, nu);
    brk_q += nu;
    link_block(hdr);
    return 1;
  endfunction

  // First-fit search from the rover; split off the tail of a larger block
  function automatic logic [IDX_W-1:0] grant_addr(int unsigned nbytes);
    int unsigned need;
    int unsigned prev;
    int unsigned p;
    int unsigned sz;
    int unsigned steps;
    need = (nbytes + UNIT_BYTES - 1) / UNIT_BYTES + 1;
    if (!started_q) begin
      wr_next(0, 0);
      wr_size(0, 0);
      rover_q = 0;
      started_q = 1;
    end
    prev = rover_q;
    p = rd_next(prev);
    steps = 0;
    while (1) begin
      sz = rd_size(p);
      if (sz >= need) begin
        if (sz == need) begin
          wr_next(prev, rd_next(p));
        end else begin
          sz -= need;
          wr_size(p, sz);
          p += sz;
          wr_size(p, need);
        end
        rover_q = prev;
        return IDX_W'(p + 1);
      end
      if (p == rover_q) begin
        if (!grow_heap(need)) return '0;
        p = rover_q;
      end
      prev = p;
      p = rd_next(p);
      steps++;
      if (steps > WALK_LIMIT) return '0;
    end
  endfunction

  function automatic logic [IDX_W-1:0] predict_item(logic op, logic [BYTES_W-1:0] nbytes,
                                                    logic [IDX_W-1:0] baddr);
    logic [IDX_W-1:0] res;
    res = '0;
    if (fla_op_t'(op) == OP_ALLOC) begin
      res = grant_addr(nbytes);
    end else if (started_q && baddr >= 2 && int'(baddr) - 1 < brk_q) begin
      link_block(int'(baddr) - 1);
    end
    return res;
  endfunction

  // Predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin
    logic [IDX_W-1:0] want;
    if (!rst_n) begin
      rover_q = 0;
      brk_q = 1;
      started_q = 0;
      grow_min_q = MIN_GROW_RESET;
      addr_due.delete();
      fail_count = 0;
      due_count = 0;
    end else begin
      if (cfg_we) grow_min_q = cfg_wdata;
      if (req.valid && req.ready)
        addr_due.push_back(predict_item(req.operation, req.request_bytes,
                                        req.block_address));
      if (rsp.valid && rsp.ready) begin
        if (addr_due.size() == 0) begin
          $error("result_address: no item expected, actual %0d", rsp.result_address);
          fail_count++;
        end else begin
          want = addr_due.pop_front();
          if (rsp.result_address !== want) begin
            $error("result_address: expected %0d, actual %0d", want, rsp.result_address);
            fail_count++;
          end
        end
      end
      due_count = addr_due.size();
    end
  end

endmodule

FILE: dv/tb_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_free_list_allocator_core
// Drives allocate and free items into the allocator under varying sender and
// receiver idling and grow-size settings; frees mostly blocks it was granted,
// plus some invalid addresses. The checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_free_list_allocator_core;
  import fla_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int HOLD_CYCLES = 400;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_wdata;
  int               fail_count;
  int               due_count;
  int               tx_idle_pct;
  int               rx_idle_pct;
  int               hold_seq;
  int               hold_seen = 0;
  int               hold_left = 0;
  int               cycles = 0;
  logic             op_q [$];
  logic [IDX_W-1:0] live_q [$];

  fla_req_if req ();
  fla_rsp_if rsp ();

  free_list_allocator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req),
    .out_rsp   (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  fla_tb_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .rsp        (rsp),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random idling, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp.ready <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
      rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Track granted addresses so that only live blocks are freed
  always @(posedge clk) begin
    logic op;
    if (rst_n) begin
      if (req.valid && req.ready) op_q.push_back(req.operation);
      if (rsp.valid && rsp.ready && op_q.size() > 0) begin
        op = op_q.pop_front();
        if (fla_op_t'(op) == OP_ALLOC && rsp.result_address != 0)
          live_q.push_back(rsp.result_address);
      end
    end
  end

  // Offer one item and hold it until accepted; idle cycles before it at random
  task automatic send_item(fla_op_t op, logic [BYTES_W-1:0] nbytes, logic [IDX_W-1:0] baddr);
    while ($urandom_range(99) < tx_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid         <= 1'b1;
    req.operation     <= op;
    req.request_bytes <= nbytes;
    req.block_address <= baddr;
    do @(posedge clk); while (!(req.valid && req.ready));
  endtask

  task automatic send_alloc(logic [BYTES_W-1:0] nbytes);
    send_item(OP_ALLOC, nbytes, IDX_W'($urandom));
  endtask

  task automatic free_live(int k);
    logic [IDX_W-1:0] a;
    a = live_q[k];
    live_q.delete(k);
    send_item(OP_FREE, BYTES_W'($urandom), a);
  endtask

  // Drain all results, then update the grow size while the block is idle
  task automatic drain_and_cfg(logic [IDX_W-1:0] v);
    req.valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_items(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (live_q.size() > 0 && (r < 45 || live_q.size() > 120)) begin
        if ($urandom_range(9) == 0)
          send_item(OP_FREE, BYTES_W'($urandom), IDX_W'($urandom_range(1)));
        else
          free_live($urandom_range(live_q.size() - 1));
      end else begin
        r = $urandom_range(99);
        if (r < 80)      send_alloc(BYTES_W'($urandom_range(64)));
        else if (r < 95) send_alloc(BYTES_W'($urandom_range(1023)));
        else if (r < 98) send_alloc(BYTES_W'($urandom));
        else             send_alloc(BYTES_W'(16'hFFFF - $urandom_range(40)));
      end
    end
  endtask

  initial begin
    hold_seq    = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    req.valid         = 1'b0;
    req.operation     = OP_ALLOC;
    req.request_bytes = '0;
    req.block_address = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: frees before the list exists, size edges, oversized requests
    send_item(OP_FREE, 16'hFFFF, 12'd5);
    send_item(OP_FREE, 16'h0000, 12'hFFF);
    send_alloc(16'd0);
    send_alloc(16'd1);
    send_alloc(16'd16);
    send_alloc(16'd17);
    send_alloc(16'hFFFF);
    send_alloc(16'd65520);
    send_alloc(16'd200);
    send_item(OP_FREE, 16'hAAAA, 12'd1);
    send_item(OP_FREE, 16'h5555, 12'd0);
    send_item(OP_FREE, 16'h0000, 12'hFFF);
    drain_and_cfg(12'd1);
    send_alloc(16'd48);
    send_alloc(16'd48);
    send_alloc(16'd1000);
    drain_and_cfg(12'd1);
    // Free in mixed order to merge with upper and lower neighbors
    while (live_q.size() > 0) free_live(live_q.size() > 1 ? 1 : 0);
    send_alloc(16'd32);
    send_alloc(16'd4000);

    // Random phases with different idling and grow sizes
    drain_and_cfg(12'd4095);
    tx_idle_pct = 24; rx_idle_pct = 88;
    random_items(310);
    drain_and_cfg(12'd1);
    tx_idle_pct = 88; rx_idle_pct = 24;
    random_items(310);
    drain_and_cfg(IDX_W'($urandom_range(64, 2)));
    tx_idle_pct = 0; rx_idle_pct = 0;
    hold_seq++;
    random_items(310);
    drain_and_cfg(12'd4);
    random_items(310);

    req.valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
